[sv/sixfk_pkg.sv]
// Shared constants and tables for the six-axis forward kinematics block.
package sixfk_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int WORK_BITS    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int ROT_W        = 32;
  localparam int PHASE_W      = 32;
  localparam int LANE_W       = PHASE_W + 1;
  localparam int JOINTS       = 6;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int QUEUE_DEPTH = 4;

  localparam int LINK_ONE_MILLI   = 491;
  localparam int LINK_TWO_MILLI   = 450;
  localparam int LINK_THREE_MILLI = 450;
  localparam int LINK_FOUR_MILLI  = 84;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINK_ONE   = 3'd0,
    REG_LINK_TWO   = 3'd1,
    REG_LINK_THREE = 3'd2,
    REG_LINK_FOUR  = 3'd3
  } cfg_reg_t;

  localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

[sv/sixfk_front.sv]
// Input stage: takes a pose request and folds each joint angle into the CORDIC range.
module sixfk_front import sixfk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ANGLE_BITS-1:0]      angle_joint_one,
  input  logic signed [ANGLE_BITS-1:0]      angle_joint_two,
  input  logic signed [ANGLE_BITS-1:0]      angle_joint_three,
  input  logic signed [ANGLE_BITS-1:0]      angle_joint_four,
  input  logic signed [ANGLE_BITS-1:0]      angle_joint_five,
  input  logic signed [ANGLE_BITS-1:0]      angle_joint_six,
  output logic                              push,
  input  logic                              queue_full,
  output logic [JOINTS*LANE_W-1:0]          push_data
);

  logic [ANGLE_BITS-1:0]     angles [JOINTS];
  logic [JOINTS*LANE_W-1:0]  lanes;
  logic                      held;
  logic [JOINTS*LANE_W-1:0]  held_data;

  // A phase in the left half plane is turned by half a turn; the flag
  // tells the back end to negate sine and cosine.
  function automatic logic [LANE_W-1:0] classify(input logic [ANGLE_BITS-1:0] ang);
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] probe;
    logic               flip;
    ph    = {ang, {(PHASE_W-ANGLE_BITS){1'b0}}};
    probe = ph + 32'h4000_0000;
    flip  = probe[PHASE_W-1];
    return {flip, ph ^ {flip, {(PHASE_W-1){1'b0}}}};
  endfunction

  assign angles[0] = angle_joint_one;
  assign angles[1] = angle_joint_two;
  assign angles[2] = angle_joint_three;
  assign angles[3] = angle_joint_four;
  assign angles[4] = angle_joint_five;
  assign angles[5] = angle_joint_six;

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      lanes[j*LANE_W +: LANE_W] = classify(angles[j]);
    end
  end

  assign in_stall  = held && queue_full;
  assign push      = held && !queue_full;
  assign push_data = held_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_data <= lanes;
    end
  end

endmodule

[sv/sixfk_fifo.sv]
// Short request queue between the input stage and the kinematics pipeline.
module sixfk_fifo import sixfk_pkg::*; #(
  parameter int DATA_W = LANE_W,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data,
  output logic [CNT_W-1:0]  count
);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/sixfk_cordic.sv]
// Pipelined rotation-mode CORDIC lane giving cosine and sine of one joint in Q30.
module sixfk_cordic import sixfk_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [LANE_W-1:0]       lane,
  output logic signed [ROT_W-1:0] cos_out,
  output logic signed [ROT_W-1:0] sin_out
);

  logic signed [CORDIC_W-1:0] xs [1:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] ys [1:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] zs [1:CORDIC_STEPS];
  logic                       flips [1:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    logic signed [CORDIC_W-1:0] xp, yp, zp, xsh, ysh, at;
    logic                       fp;
    if (adv) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (i == 0) begin
          xp = CORDIC_GAIN;
          yp = '0;
          zp = CORDIC_W'(signed'(lane[PHASE_W-1:0]));
          fp = lane[PHASE_W];
        end else begin
          xp = xs[i];
          yp = ys[i];
          zp = zs[i];
          fp = flips[i];
        end
        xsh = xp >>> i;
        ysh = yp >>> i;
        at  = CORDIC_W'(ATAN_TABLE[i]);
        if (!zp[CORDIC_W-1]) begin
          xs[i+1] <= xp - ysh;
          ys[i+1] <= yp + xsh;
          zs[i+1] <= zp - at;
        end else begin
          xs[i+1] <= xp + ysh;
          ys[i+1] <= yp - xsh;
          zs[i+1] <= zp + at;
        end
        flips[i+1] <= fp;
      end
      cos_out <= flips[CORDIC_STEPS] ? ROT_W'(-xs[CORDIC_STEPS]) : ROT_W'(xs[CORDIC_STEPS]);
      sin_out <= flips[CORDIC_STEPS] ? ROT_W'(-ys[CORDIC_STEPS]) : ROT_W'(ys[CORDIC_STEPS]);
    end
  end

endmodule

[sv/sixfk_back.sv]
// Kinematics pipeline: joint transforms, the chained product and the output register.
module sixfk_back import sixfk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int LW = FRAC_BITS + 1,
  localparam int RO_W = FRAC_BITS + 2,
  localparam int PO_W = FRAC_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop,
  input  logic [JOINTS*LANE_W-1:0]     pop_data,
  input  logic [LW-1:0]                link_one,
  input  logic [LW-1:0]                link_two,
  input  logic [LW-1:0]                link_three,
  input  logic [LW-1:0]                link_four,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [RO_W-1:0]       rot_r0c0,
  output logic signed [RO_W-1:0]       rot_r0c1,
  output logic signed [RO_W-1:0]       rot_r0c2,
  output logic signed [RO_W-1:0]       rot_r1c0,
  output logic signed [RO_W-1:0]       rot_r1c1,
  output logic signed [RO_W-1:0]       rot_r1c2,
  output logic signed [RO_W-1:0]       rot_r2c0,
  output logic signed [RO_W-1:0]       rot_r2c1,
  output logic signed [RO_W-1:0]       rot_r2c2,
  output logic signed [PO_W-1:0]       pos_x,
  output logic signed [PO_W-1:0]       pos_y,
  output logic signed [PO_W-1:0]       pos_z
);

  localparam int HW     = LW + 3;
  localparam int PW     = FRAC_BITS + 8;
  localparam int PRW    = 2 * ROT_W;
  localparam int PPW    = ROT_W + PW;
  localparam int JPW    = ROT_W + 1 + HW;
  localparam int FPW    = ROT_W + HW;
  localparam int SUM_W  = 2 * ROT_W + 2;
  localparam int STAGES = CORDIC_STEPS + 15;
  localparam int RSH    = WORK_BITS - FRAC_BITS;

  // Joints one, four and six turn about z and carry no offset.
  localparam logic [JOINTS-1:0] ABOUT_Z = 6'b101001;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (WORK_BITS - 1);
  localparam logic signed [ROT_W-1:0] ONE_R    = ROT_W'(1) << WORK_BITS;
  localparam logic signed [ROT_W:0]   ONE_E    = (ROT_W+1)'(1) << WORK_BITS;
  localparam logic signed [ROT_W:0]   ROT_HALF = (ROT_W+1)'(1) << (RSH - 1);
  localparam logic signed [ROT_W:0]   ROT_HI   = (ROT_W+1)'(1) << FRAC_BITS;
  localparam logic signed [ROT_W:0]   ROT_LO   = -ROT_HI;
  localparam logic signed [PW-1:0]    POS_HI   = (PW'(1) << (PO_W - 1)) - PW'(1);
  localparam logic signed [PW-1:0]    POS_LO   = -POS_HI - PW'(1);

  logic adv;
  logic vld [1:STAGES];

  logic signed [ROT_W-1:0] cos_c [JOINTS];
  logic signed [ROT_W-1:0] sin_c [JOINTS];
  logic signed [HW-1:0]    hgt [JOINTS];
  logic signed [HW-1:0]    lsum;
  logic signed [ROT_W:0]   neg_s [JOINTS];
  logic signed [ROT_W:0]   om_c [JOINTS];

  logic signed [ROT_W-1:0] j1_c [JOINTS];
  logic signed [ROT_W-1:0] j1_s [JOINTS];
  logic signed [JPW-1:0]   j1_px [JOINTS];
  logic signed [JPW-1:0]   j1_pz [JOINTS];

  logic signed [ROT_W-1:0] gs_r [6][JOINTS][3][3];
  logic signed [PW-1:0]    gs_p [6][JOINTS][3];
  logic signed [ROT_W-1:0] acc_r [6][3][3];
  logic signed [PW-1:0]    acc_p [6][3];

  logic signed [PRW-1:0]   pm_r [1:5][3][3][3];
  logic signed [PPW-1:0]   pm_p [1:5][3][3];
  logic signed [PW-1:0]    am_p [1:5][3];
  logic signed [ROT_W-1:0] gm_r [1:5][JOINTS][3][3];
  logic signed [PW-1:0]    gm_p [1:5][JOINTS][3];

  logic signed [RO_W-1:0]  fm_rot [3][3];
  logic signed [FPW-1:0]   fm_prod [3];
  logic signed [PW-1:0]    fm_p [3];

  logic signed [RO_W-1:0]  rot_q [3][3];
  logic signed [PO_W-1:0]  pos_q [3];

  function automatic logic signed [SUM_W-1:0] round30(input logic signed [SUM_W-1:0] v);
    return (v + RND_HALF) >>> WORK_BITS;
  endfunction

  function automatic logic signed [RO_W-1:0] rot_fin(input logic signed [ROT_W:0] v);
    logic signed [ROT_W:0] t;
    t = (v + ROT_HALF) >>> RSH;
    if (t > ROT_HI) begin
      t = ROT_HI;
    end else if (t < ROT_LO) begin
      t = ROT_LO;
    end
    return RO_W'(t);
  endfunction

  function automatic logic signed [PO_W-1:0] pos_fin(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v;
    if (t > POS_HI) begin
      t = POS_HI;
    end else if (t < POS_LO) begin
      t = POS_LO;
    end
    return PO_W'(t);
  endfunction

  assign adv       = !vld[STAGES] || !out_stall;
  assign pop       = adv && pop_valid;
  assign out_valid = vld[STAGES];

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    sixfk_cordic u_cordic (
      .clk     (clk),
      .adv     (adv),
      .lane    (pop_data[j*LANE_W +: LANE_W]),
      .cos_out (cos_c[j]),
      .sin_out (sin_c[j])
    );
  end

  // Axis heights; user must change links only with nothing in flight (not enforced).
  always_comb begin
    hgt[0] = '0;
    hgt[1] = HW'(link_one);
    hgt[2] = HW'(link_one) + HW'(link_two);
    hgt[3] = '0;
    hgt[4] = HW'(link_one) + HW'(link_two) + HW'(link_three);
    hgt[5] = '0;
    lsum   = hgt[4] + HW'(link_four);
    for (int j = 0; j < JOINTS; j++) begin
      neg_s[j] = -((ROT_W+1)'(sin_c[j]));
      om_c[j]  = ONE_E - (ROT_W+1)'(cos_c[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 1; n <= STAGES; n++) begin
        vld[n] <= 1'b0;
      end
    end else if (adv) begin
      vld[1] <= pop;
      for (int n = 2; n <= STAGES; n++) begin
        vld[n] <= vld[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Joint offset products.
      for (int j = 0; j < JOINTS; j++) begin
        j1_c[j]  <= cos_c[j];
        j1_s[j]  <= sin_c[j];
        j1_px[j] <= neg_s[j] * hgt[j];
        j1_pz[j] <= om_c[j] * hgt[j];
      end

      // Joint transforms.
      for (int j = 0; j < JOINTS; j++) begin
        if (ABOUT_Z[j]) begin
          gs_r[0][j][0][0] <= j1_c[j];
          gs_r[0][j][0][1] <= -j1_s[j];
          gs_r[0][j][0][2] <= '0;
          gs_r[0][j][1][0] <= j1_s[j];
          gs_r[0][j][1][1] <= j1_c[j];
          gs_r[0][j][1][2] <= '0;
          gs_r[0][j][2][0] <= '0;
          gs_r[0][j][2][1] <= '0;
          gs_r[0][j][2][2] <= ONE_R;
          gs_p[0][j][0]    <= '0;
          gs_p[0][j][2]    <= '0;
        end else begin
          gs_r[0][j][0][0] <= j1_c[j];
          gs_r[0][j][0][1] <= '0;
          gs_r[0][j][0][2] <= j1_s[j];
          gs_r[0][j][1][0] <= '0;
          gs_r[0][j][1][1] <= ONE_R;
          gs_r[0][j][1][2] <= '0;
          gs_r[0][j][2][0] <= -j1_s[j];
          gs_r[0][j][2][1] <= '0;
          gs_r[0][j][2][2] <= j1_c[j];
          gs_p[0][j][0]    <= PW'(round30(SUM_W'(j1_px[j])));
          gs_p[0][j][2]    <= PW'(round30(SUM_W'(j1_pz[j])));
        end
        gs_p[0][j][1] <= '0;
      end
      acc_r[0][0][0] <= j1_c[0];
      acc_r[0][0][1] <= -j1_s[0];
      acc_r[0][0][2] <= '0;
      acc_r[0][1][0] <= j1_s[0];
      acc_r[0][1][1] <= j1_c[0];
      acc_r[0][1][2] <= '0;
      acc_r[0][2][0] <= '0;
      acc_r[0][2][1] <= '0;
      acc_r[0][2][2] <= ONE_R;
      for (int i = 0; i < 3; i++) begin
        acc_p[0][i] <= '0;
      end

      // Chained product, left to right: a multiply stage then a sum stage per joint.
      for (int k = 1; k < JOINTS; k++) begin
        for (int i = 0; i < 3; i++) begin
          for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
              pm_r[k][i][j][m] <= acc_r[k-1][i][m] * gs_r[k-1][k][m][j];
            end
            pm_p[k][i][m] <= acc_r[k-1][i][m] * gs_p[k-1][k][m];
          end
          am_p[k][i] <= acc_p[k-1][i];
        end
        gm_r[k] <= gs_r[k-1];
        gm_p[k] <= gs_p[k-1];

        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            acc_r[k][i][j] <= ROT_W'(round30(SUM_W'(pm_r[k][i][j][0])
                                              + SUM_W'(pm_r[k][i][j][1])
                                              + SUM_W'(pm_r[k][i][j][2])));
          end
          acc_p[k][i] <= PW'(round30(SUM_W'(pm_p[k][i][0]) + SUM_W'(pm_p[k][i][1])
                                     + SUM_W'(pm_p[k][i][2]))) + am_p[k][i];
        end
        gs_r[k] <= gm_r[k];
        gs_p[k] <= gm_p[k];
      end

      // Home pose: the first two columns are negated, the tool sits up the z column.
      for (int i = 0; i < 3; i++) begin
        fm_rot[i][0] <= rot_fin(-((ROT_W+1)'(acc_r[5][i][0])));
        fm_rot[i][1] <= rot_fin(-((ROT_W+1)'(acc_r[5][i][1])));
        fm_rot[i][2] <= rot_fin((ROT_W+1)'(acc_r[5][i][2]));
        fm_prod[i]   <= acc_r[5][i][2] * lsum;
        fm_p[i]      <= acc_p[5][i];
      end

      for (int i = 0; i < 3; i++) begin
        rot_q[i] <= fm_rot[i];
        pos_q[i] <= pos_fin(fm_p[i] + PW'(round30(SUM_W'(fm_prod[i]))));
      end
    end
  end

  assign rot_r0c0 = rot_q[0][0];
  assign rot_r0c1 = rot_q[0][1];
  assign rot_r0c2 = rot_q[0][2];
  assign rot_r1c0 = rot_q[1][0];
  assign rot_r1c1 = rot_q[1][1];
  assign rot_r1c2 = rot_q[1][2];
  assign rot_r2c0 = rot_q[2][0];
  assign rot_r2c1 = rot_q[2][1];
  assign rot_r2c2 = rot_q[2][2];
  assign pos_x    = pos_q[0];
  assign pos_y    = pos_q[1];
  assign pos_z    = pos_q[2];

endmodule

[sv/six_axis_forward_kinematics.sv]
// Throughput: one pose per cycle; set by the 30-stage CORDIC lanes and the product pipeline,
// which advance together whenever the output register is free.
// A four-entry queue lets requests keep arriving for a while during an output stall.
// Reset clears the queue and all valid flags and loads the default link lengths.
module six_axis_forward_kinematics import sixfk_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [FRAC_BITS:0]            cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [ANGLE_BITS-1:0]  angle_joint_one,
  input  logic signed [ANGLE_BITS-1:0]  angle_joint_two,
  input  logic signed [ANGLE_BITS-1:0]  angle_joint_three,
  input  logic signed [ANGLE_BITS-1:0]  angle_joint_four,
  input  logic signed [ANGLE_BITS-1:0]  angle_joint_five,
  input  logic signed [ANGLE_BITS-1:0]  angle_joint_six,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FRAC_BITS+1:0]   rot_r0c0,
  output logic signed [FRAC_BITS+1:0]   rot_r0c1,
  output logic signed [FRAC_BITS+1:0]   rot_r0c2,
  output logic signed [FRAC_BITS+1:0]   rot_r1c0,
  output logic signed [FRAC_BITS+1:0]   rot_r1c1,
  output logic signed [FRAC_BITS+1:0]   rot_r1c2,
  output logic signed [FRAC_BITS+1:0]   rot_r2c0,
  output logic signed [FRAC_BITS+1:0]   rot_r2c1,
  output logic signed [FRAC_BITS+1:0]   rot_r2c2,
  output logic signed [FRAC_BITS+2:0]   pos_x,
  output logic signed [FRAC_BITS+2:0]   pos_y,
  output logic signed [FRAC_BITS+2:0]   pos_z
);

  localparam int LW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QW    = JOINTS * LANE_W;

  localparam logic [LW-1:0] LINK_ONE_RST =
    LW'(((64'(LINK_ONE_MILLI) << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [LW-1:0] LINK_TWO_RST =
    LW'(((64'(LINK_TWO_MILLI) << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [LW-1:0] LINK_THREE_RST =
    LW'(((64'(LINK_THREE_MILLI) << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [LW-1:0] LINK_FOUR_RST =
    LW'(((64'(LINK_FOUR_MILLI) << FRAC_BITS) + 64'd500) / 64'd1000);

  logic [LW-1:0]    link_one;
  logic [LW-1:0]    link_two;
  logic [LW-1:0]    link_three;
  logic [LW-1:0]    link_four;

  logic             push;
  logic [QW-1:0]    push_data;
  logic             queue_full;
  logic             pop;
  logic             pop_valid;
  logic [QW-1:0]    pop_data;
  logic [CNT_W-1:0] fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_one   <= LINK_ONE_RST;
      link_two   <= LINK_TWO_RST;
      link_three <= LINK_THREE_RST;
      link_four  <= LINK_FOUR_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_LINK_ONE:   link_one   <= cfg_data;
        REG_LINK_TWO:   link_two   <= cfg_data;
        REG_LINK_THREE: link_three <= cfg_data;
        REG_LINK_FOUR:  link_four  <= cfg_data;
        default: ;
      endcase
    end
  end

  sixfk_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .angle_joint_one   (angle_joint_one),
    .angle_joint_two   (angle_joint_two),
    .angle_joint_three (angle_joint_three),
    .angle_joint_four  (angle_joint_four),
    .angle_joint_five  (angle_joint_five),
    .angle_joint_six   (angle_joint_six),
    .push              (push),
    .queue_full        (queue_full),
    .push_data         (push_data)
  );

  sixfk_fifo #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .count     (fifo_count)
  );

  sixfk_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data),
    .link_one   (link_one),
    .link_two   (link_two),
    .link_three (link_three),
    .link_four  (link_four),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rot_r0c0   (rot_r0c0),
    .rot_r0c1   (rot_r0c1),
    .rot_r0c2   (rot_r0c2),
    .rot_r1c0   (rot_r1c0),
    .rot_r1c1   (rot_r1c1),
    .rot_r1c2   (rot_r1c2),
    .rot_r2c0   (rot_r2c0),
    .rot_r2c1   (rot_r2c1),
    .rot_r2c2   (rot_r2c2),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(QUEUE_DEPTH))
    else $error("request queue holds more than its depth");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (fifo_count == CNT_W'(QUEUE_DEPTH)))
    else $error("input stalled while the request queue has room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && fifo_count == '0))
    else $error("pipeline not empty after reset");

endmodule

[test/six_axis_forward_kinematics_checker.sv]
// Checker for the six-axis forward kinematics block: pose predictor and result comparison.
module six_axis_forward_kinematics_checker import sixfk_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [16:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic signed [15:0]  angle_joint_one,
  input  logic signed [15:0]  angle_joint_two,
  input  logic signed [15:0]  angle_joint_three,
  input  logic signed [15:0]  angle_joint_four,
  input  logic signed [15:0]  angle_joint_five,
  input  logic signed [15:0]  angle_joint_six,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [17:0]  rot_r0c0,
  input  logic signed [17:0]  rot_r0c1,
  input  logic signed [17:0]  rot_r0c2,
  input  logic signed [17:0]  rot_r1c0,
  input  logic signed [17:0]  rot_r1c1,
  input  logic signed [17:0]  rot_r1c2,
  input  logic signed [17:0]  rot_r2c0,
  input  logic signed [17:0]  rot_r2c1,
  input  logic signed [17:0]  rot_r2c2,
  input  logic signed [18:0]  pos_x,
  input  logic signed [18:0]  pos_y,
  input  logic signed [18:0]  pos_z,
  output int                  fail_count,
  output int                  poses_pending,
  output logic                any_accept
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNITY = 64'sd1 << WORK_BITS;

  typedef struct {
    longint r[3][3];
    longint p[3];
  } frame_t;

  typedef struct {
    logic signed [17:0] rot[9];
    logic signed [18:0] pos[3];
  } pose_result_t;

  pose_result_t expected_poses[$];
  longint link_len[4];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic void cordic_sin_cos(logic [15:0] ang, output longint c, output longint s);
    logic [31:0] ph;
    logic        flip;
    longint      x, y, z, xs, ys;
    ph = {ang, 16'h0000};
    flip = ph[31] ^ ph[30];
    if (flip) ph[31] = ~ph[31];
    z = longint'($signed(ph));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TABLE[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TABLE[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic frame_t joint_frame(logic about_z, longint h, logic [15:0] ang);
    frame_t g;
    longint c, s;
    cordic_sin_cos(ang, c, s);
    g.r = '{'{c, -s, 0}, '{s, c, 0}, '{0, 0, UNITY}};
    g.p = '{0, 0, 0};
    if (!about_z) begin
      g.r = '{'{c, 0, s}, '{0, UNITY, 0}, '{-s, 0, c}};
      g.p[0] = round_shr(-s * h, WORK_BITS);
      g.p[2] = round_shr((UNITY - c) * h, WORK_BITS);
    end
    return g;
  endfunction

  function automatic frame_t chain(frame_t a, frame_t b);
    frame_t t;
    longint acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a.r[i][k] * b.r[k][j];
        t.r[i][j] = round_shr(acc, WORK_BITS);
      end
      acc = 0;
      for (int k = 0; k < 3; k++) acc += a.r[i][k] * b.p[k];
      t.p[i] = round_shr(acc, WORK_BITS) + a.p[i];
    end
    return t;
  endfunction

  function automatic pose_result_t end_pose(logic [15:0] ang[6]);
    logic   axis_is_z[6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    longint height[6];
    longint v;
    frame_t acc;
    pose_result_t res;
    height = '{0, link_len[0], link_len[0] + link_len[1], 0,
               link_len[0] + link_len[1] + link_len[2], 0};
    acc = joint_frame(axis_is_z[0], height[0], ang[0]);
    for (int i = 1; i < 6; i++) acc = chain(acc, joint_frame(axis_is_z[i], height[i], ang[i]));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // The home pose flips the first two columns.
        v = round_shr(j < 2 ? -acc.r[i][j] : acc.r[i][j], WORK_BITS - 16);
        if (v > 65536) v = 65536;
        if (v < -65536) v = -65536;
        res.rot[i*3+j] = v[17:0];
      end
      v = acc.p[i] + round_shr(acc.r[i][2] *
          (link_len[0] + link_len[1] + link_len[2] + link_len[3]), WORK_BITS);
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      res.pos[i] = v[18:0];
    end
    return res;
  endfunction

  logic signed [17:0] rot_seen[9];
  logic signed [18:0] pos_seen[3];
  string rot_names[9] = '{"rot_r0c0", "rot_r0c1", "rot_r0c2", "rot_r1c0", "rot_r1c1",
                          "rot_r1c2", "rot_r2c0", "rot_r2c1", "rot_r2c2"};
  string pos_names[3] = '{"pos_x", "pos_y", "pos_z"};

  assign rot_seen = '{rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                      rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2};
  assign pos_seen = '{pos_x, pos_y, pos_z};
  assign any_accept = (in_valid && !in_stall) || (out_valid && !out_stall);

  initial fail_count = 0;
  initial poses_pending = 0;

  always @(posedge clk) begin
    pose_result_t want;
    logic [15:0] ang[6];
    if (rst) begin
      link_len = '{32178, 29491, 29491, 5505};
      expected_poses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_poses.pop_front();
          for (int i = 0; i < 9; i++)
            if (rot_seen[i] !== want.rot[i]) begin
              $error("%s expected %0d actual %0d", rot_names[i], want.rot[i], rot_seen[i]);
              fail_count++;
            end
          for (int i = 0; i < 3; i++)
            if (pos_seen[i] !== want.pos[i]) begin
              $error("%s expected %0d actual %0d", pos_names[i], want.pos[i], pos_seen[i]);
              fail_count++;
            end
        end
      end
      if (in_valid && !in_stall) begin
        ang = '{angle_joint_one, angle_joint_two, angle_joint_three,
                angle_joint_four, angle_joint_five, angle_joint_six};
        expected_poses.push_back(end_pose(ang));
      end
      if (cfg_write_en && cfg_index <= REG_LINK_FOUR) link_len[cfg_index] = longint'(cfg_data);
    end
    poses_pending = expected_poses.size();
  end
endmodule

[test/tb_six_axis_forward_kinematics.sv]
// Testbench top for the six-axis forward kinematics block: stimulus and verdict.
module tb_six_axis_forward_kinematics import sixfk_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 46;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LINK_ONE;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] ang [6] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] rot [9];
  logic signed [18:0] pos [3];
  int fail_count, poses_pending, idle_cycles;
  logic any_accept;
  logic long_hold = 1'b0;
  logic stall_random = 1'b0;

  always #1 clk = ~clk;

  six_axis_forward_kinematics dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .angle_joint_one(ang[0]), .angle_joint_two(ang[1]), .angle_joint_three(ang[2]),
    .angle_joint_four(ang[3]), .angle_joint_five(ang[4]), .angle_joint_six(ang[5]),
    .out_valid, .out_stall,
    .rot_r0c0(rot[0]), .rot_r0c1(rot[1]), .rot_r0c2(rot[2]), .rot_r1c0(rot[3]),
    .rot_r1c1(rot[4]), .rot_r1c2(rot[5]), .rot_r2c0(rot[6]), .rot_r2c1(rot[7]),
    .rot_r2c2(rot[8]), .pos_x(pos[0]), .pos_y(pos[1]), .pos_z(pos[2])
  );

  six_axis_forward_kinematics_checker pose_checker (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .angle_joint_one(ang[0]), .angle_joint_two(ang[1]), .angle_joint_three(ang[2]),
    .angle_joint_four(ang[3]), .angle_joint_five(ang[4]), .angle_joint_six(ang[5]),
    .out_valid, .out_stall,
    .rot_r0c0(rot[0]), .rot_r0c1(rot[1]), .rot_r0c2(rot[2]), .rot_r1c0(rot[3]),
    .rot_r1c1(rot[4]), .rot_r1c2(rot[5]), .rot_r2c0(rot[6]), .rot_r2c1(rot[7]),
    .rot_r2c2(rot[8]), .pos_x(pos[0]), .pos_y(pos[1]), .pos_z(pos[2]),
    .fail_count, .poses_pending, .any_accept
  );

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Receiver stalls: random gaps, or one long hold while the sender keeps going.
  always @(posedge clk) begin
    int hold;
    if (long_hold) begin
      out_stall <= 1'b1;
      hold = 300;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
      wait (!long_hold);
    end else if (stall_random && gap_length() != 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || any_accept) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Valid stays high from one request to the next when there is no gap.
  task automatic send_request(logic [15:0] a[6], bit gaps);
    int gap;
    gap = gaps ? gap_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 6; i++) ang[i] <= a[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(bit gaps);
    logic [15:0] a[6];
    int mode;
    for (int i = 0; i < 6; i++) begin
      mode = $urandom_range(9);
      if (mode == 0) a[i] = 16'h8000;
      else if (mode == 1) a[i] = 16'h4000 ^ 16'($urandom_range(1)) << 15;
      else if (mode == 2) a[i] = 16'($urandom_range(3)) - 16'd1;
      else a[i] = 16'($urandom);
    end
    send_request(a, gaps);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    wait (poses_pending == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_link(cfg_reg_t idx, logic [16:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] a[6];
    logic [15:0] corners[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                                 16'hC000, 16'h0001, 16'hFFFF, 16'h2000};
    logic [16:0] link_sets[4][4] = '{
      '{17'd32178, 17'd29491, 17'd29491, 17'd5505},
      '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF},
      '{17'd0, 17'd0, 17'd0, 17'd0},
      '{17'h1FFFF, 17'd0, 17'h15555, 17'h0AAAA}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: every angle takes each corner value in turn.
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 6; i++) a[i] = corners[(k + i) % 8];
      send_request(a, 1'b0);
    end
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 6; i++) a[i] = corners[k];
      send_request(a, 1'b0);
    end
    drain_and_settle();

    for (int set = 0; set < 5; set++) begin
      if (set < 4) begin
        for (int r = 0; r < 4; r++) write_link(cfg_reg_t'(r), link_sets[set][r]);
      end else begin
        for (int r = 0; r < 4; r++) write_link(cfg_reg_t'(r), 17'($urandom));
      end
      write_link(cfg_reg_t'(3'd5), 17'h1FFFF);
      cfg_write_en <= 1'b0;
      stall_random <= 1'b1;
      if (set == 1) begin
        // Enough requests to fill the pipeline and the queue behind the held output.
        long_hold <= 1'b1;
        repeat (70) send_random(1'b0);
        long_hold <= 1'b0;
      end
      repeat (set == 0 ? 260 : 100) send_random(1'b1);
      // The sender pauses here until every result has come.
      stall_random <= 1'b0;
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    rst <= 1'b1;
  end
endmodule

[six_axis_forward_kinematics.f]
sv/sixfk_pkg.sv
sv/sixfk_front.sv
sv/sixfk_fifo.sv
sv/sixfk_cordic.sv
sv/sixfk_back.sv
sv/six_axis_forward_kinematics.sv
test/six_axis_forward_kinematics_checker.sv
test/tb_six_axis_forward_kinematics.sv
